// ===== sv/pole_pkg.sv =====
// Package: types, codes and sizes shared by the list engine and its checker.
`timescale 1ns / 1ps
`default_nettype none
package pole_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned LenW     = $clog2(Capacity + 1);
  localparam int unsigned AddrW    = $clog2(Capacity);

  typedef enum logic [3:0] {
    OP_CLEAR      = 4'd0,
    OP_INS_FIRST  = 4'd1,
    OP_INS_AT     = 4'd2,
    OP_INS_MID    = 4'd3,
    OP_INS_LAST   = 4'd4,
    OP_READ_ALL   = 4'd5,
    OP_DEL_FIRST  = 4'd6,
    OP_DEL_AT     = 4'd7,
    OP_DEL_MID    = 4'd8,
    OP_DEL_LAST   = 4'd9,
    OP_DEL_VALUE  = 4'd10,
    OP_INS_SORTED = 4'd11,
    OP_REVERSE    = 4'd12,
    OP_DEDUP      = 4'd13,
    OP_SIZE       = 4'd14,
    OP_SEARCH     = 4'd15
  } op_e;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_EMPTY    = 3'd1,
    STAT_BADPOS   = 3'd2,
    STAT_NOTFOUND = 3'd3,
    STAT_FULL     = 3'd4
  } stat_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_EX,
    S_SHR_RD,
    S_SHR_WR,
    S_DEL_RD,
    S_DEL_CAP,
    S_SHL_RD,
    S_SHL_WR,
    S_REV_RDA,
    S_REV_RDB,
    S_REV_WRA,
    S_REV_WRB,
    S_FIN
  } state_e;

  typedef struct packed {
    op_e                opcode;
    logic signed [31:0] value;
    logic [7:0]         position;
  } cmd_t;

  typedef struct packed {
    stat_e              status;
    logic signed [31:0] value_out;
    logic [7:0]         index_out;
    logic [7:0]         count_out;
    logic               last;
  } res_t;

endpackage
`default_nettype wire

// ===== sv/positional_ordered_list_engine_core.sv =====
// Top level: bounded ordered list engine with a one-write, one-read entry memory and a sequencer.
// Clear and size go straight to the final state; shifts, scans and sorted insert
//   step through the entries (each entry moved: memory read, then write back).
// Throughput: one item at a time; busy_o stays high until the final result beat is
//   registered; read_all gives one beat per element, search one per match plus a count beat.
// Reset: rst_ni low clears the length and the sequencer; entry memory is not cleared.
// Results are one-cycle strobed beats; the receiver cannot stall them.
`timescale 1ns / 1ps
`default_nettype none
module positional_ordered_list_engine_core
  import pole_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire cmd_t cmd_i,
  output logic      busy_o,
  output logic      res_valid_o,
  output res_t      res_o
);

  // Entry memory: one write and one registered read port.
  logic signed [31:0] mem [Capacity];
  logic signed [31:0] rdata_q;
  logic [AddrW-1:0]   rd_addr;
  logic               we;
  logic [AddrW-1:0]   wa;
  logic signed [31:0] wd;

  state_e state_q, state_d;

  op_e                op_q;
  logic signed [31:0] val_q;
  logic [LenW-1:0]    len_q, i_q, w_q, idx_q, cnt_q;
  logic signed [31:0] prev_q, tmp_q, vout_q;
  stat_e              st_q;
  res_t               res_q;
  logic               res_vld_q;

  logic            accept;
  logic            full;
  logic [LenW-1:0] half, mid_idx;
  logic [8:0]      pos_ext, len_p1;
  state_e          go_state;
  stat_e           go_st;
  logic [LenW-1:0] go_idx;
  logic            keep;
  logic            scan_more, shl_more, rev_more;
  logic            last_elem;

  assign accept   = start_i && (state_q == S_IDLE);
  assign full     = (len_q == LenW'(Capacity));
  assign half     = len_q >> 1;
  assign mid_idx  = (half == '0) ? LenW'(1) : half;
  assign pos_ext  = {1'b0, cmd_i.position};
  assign len_p1   = 9'(len_q) + 9'd1;
  assign scan_more = (i_q < len_q);
  assign shl_more  = ((LenW+1)'(i_q) + (LenW+1)'(1)) < (LenW+1)'(len_q);
  assign rev_more  = (i_q < half);
  assign last_elem = ((LenW+1)'(i_q) + (LenW+1)'(1)) == (LenW+1)'(len_q);
  // Dedup keeps the first element and any that differs from the last kept one;
  // delete-by-value keeps anything not equal to the operand.
  assign keep = (op_q == OP_DEDUP) ? ((i_q == '0) || (rdata_q != prev_q))
                                   : (rdata_q != val_q);

  // Decode a new command: pick the first sequencer step, error status and target index.
  always_comb begin
    go_state = S_FIN;
    go_st    = STAT_OK;
    go_idx   = '0;
    unique case (cmd_i.opcode)
      OP_CLEAR, OP_SIZE: go_state = S_FIN;
      OP_INS_FIRST: begin
        if (full) go_st = STAT_FULL;
        else go_state = S_SHR_RD;
      end
      OP_INS_AT: begin
        priority if (len_q == '0) go_st = STAT_EMPTY;
        else if (pos_ext < 9'd1 || pos_ext > len_p1) go_st = STAT_BADPOS;
        else if (full) go_st = STAT_FULL;
        else begin
          go_state = S_SHR_RD;
          go_idx   = LenW'(cmd_i.position - 8'd1);
        end
      end
      OP_INS_MID: begin
        if (full) go_st = STAT_FULL;
        else begin
          go_state = S_SHR_RD;
          go_idx   = (len_q == '0) ? '0 : mid_idx;
        end
      end
      OP_INS_LAST: begin
        if (full) go_st = STAT_FULL;
        else begin
          go_state = S_SHR_RD;
          go_idx   = len_q;
        end
      end
      OP_READ_ALL, OP_SEARCH: begin
        if (len_q == '0) go_st = STAT_EMPTY;
        else go_state = S_SCAN_RD;
      end
      OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_MID: begin
        if (len_q == '0) go_st = STAT_EMPTY;
        else begin
          go_state = S_DEL_RD;
          if (cmd_i.opcode == OP_DEL_LAST) go_idx = len_q - LenW'(1);
          else if (cmd_i.opcode == OP_DEL_MID) go_idx = (len_q == LenW'(1)) ? '0 : mid_idx;
        end
      end
      OP_DEL_AT: begin
        priority if (len_q == '0) go_st = STAT_EMPTY;
        else if (pos_ext < 9'd1 || pos_ext > 9'(len_q)) go_st = STAT_BADPOS;
        else begin
          go_state = S_DEL_RD;
          go_idx   = LenW'(cmd_i.position - 8'd1);
        end
      end
      OP_DEL_VALUE, OP_DEDUP: go_state = S_SCAN_RD;
      OP_INS_SORTED: begin
        if (full) go_st = STAT_FULL;
        else go_state = S_SCAN_RD;
      end
      OP_REVERSE: go_state = S_REV_RDA;
      default: go_state = S_FIN;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (start_i) state_d = go_state;
      S_SCAN_RD: begin
        if (scan_more) state_d = S_SCAN_EX;
        else if (op_q == OP_INS_SORTED) state_d = S_SHR_RD;
        else state_d = S_FIN;
      end
      S_SCAN_EX: begin
        priority if (op_q == OP_READ_ALL && last_elem) state_d = S_IDLE;
        else if (op_q == OP_INS_SORTED && (val_q < rdata_q)) state_d = S_SHR_RD;
        else state_d = S_SCAN_RD;
      end
      S_SHR_RD:  state_d = (i_q > idx_q) ? S_SHR_WR : S_FIN;
      S_SHR_WR:  state_d = S_SHR_RD;
      S_DEL_RD:  state_d = S_DEL_CAP;
      S_DEL_CAP: state_d = S_SHL_RD;
      S_SHL_RD:  state_d = shl_more ? S_SHL_WR : S_FIN;
      S_SHL_WR:  state_d = S_SHL_RD;
      S_REV_RDA: state_d = rev_more ? S_REV_RDB : S_FIN;
      S_REV_RDB: state_d = S_REV_WRA;
      S_REV_WRA: state_d = S_REV_WRB;
      S_REV_WRB: state_d = S_REV_RDA;
      S_FIN:     state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    rd_addr = i_q[AddrW-1:0];
    we      = 1'b0;
    wa      = i_q[AddrW-1:0];
    wd      = rdata_q;
    unique case (state_q)
      S_SCAN_EX: begin
        we = keep && (op_q == OP_DEL_VALUE || op_q == OP_DEDUP);
        wa = w_q[AddrW-1:0];
      end
      S_SHR_RD: begin
        rd_addr = AddrW'(i_q - LenW'(1));
        we      = !(i_q > idx_q);
        wa      = idx_q[AddrW-1:0];
        wd      = val_q;
      end
      S_SHR_WR:  we = 1'b1;
      S_DEL_RD:  rd_addr = idx_q[AddrW-1:0];
      S_SHL_RD:  rd_addr = AddrW'(i_q + LenW'(1));
      S_SHL_WR:  we = 1'b1;
      S_REV_RDB: rd_addr = w_q[AddrW-1:0];
      S_REV_WRA: we = 1'b1;
      S_REV_WRB: begin
        we = 1'b1;
        wa = w_q[AddrW-1:0];
        wd = tmp_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[rd_addr];
    if (we) mem[wa] <= wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      len_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      res_vld_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (accept && cmd_i.opcode == OP_CLEAR) len_q <= '0;
        S_SCAN_RD: begin
          // End of a compaction pass: the write pointer is the new length.
          if (!scan_more && (op_q == OP_DEL_VALUE || op_q == OP_DEDUP)) len_q <= w_q;
        end
        S_SHR_RD:  if (!(i_q > idx_q)) len_q <= len_q + LenW'(1);
        S_SHL_RD:  if (!shl_more) len_q <= len_q - LenW'(1);
        default: ;
      endcase
      // Result beats.
      if (state_q == S_SCAN_EX && op_q == OP_READ_ALL) begin
        res_vld_q <= 1'b1;
      end else if (state_q == S_SCAN_EX && op_q == OP_SEARCH && rdata_q == val_q) begin
        res_vld_q <= 1'b1;
      end else if (state_q == S_FIN) begin
        res_vld_q <= 1'b1;
      end
    end
  end

  // Payload and loop registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        op_q   <= cmd_i.opcode;
        val_q  <= cmd_i.value;
        st_q   <= go_st;
        idx_q  <= go_idx;
        vout_q <= '0;
        cnt_q  <= '0;
        w_q    <= (cmd_i.opcode == OP_REVERSE) ? len_q - LenW'(1) : '0;
        i_q    <= (go_state == S_SHR_RD) ? len_q : '0;
      end
      S_SCAN_RD: begin
        if (!scan_more) begin
          idx_q <= len_q;
          i_q   <= len_q;
          if (op_q == OP_DEL_VALUE && w_q == len_q) st_q <= STAT_NOTFOUND;
          if (op_q == OP_SEARCH && cnt_q == '0) st_q <= STAT_NOTFOUND;
        end
      end
      S_SCAN_EX: begin
        i_q <= i_q + LenW'(1);
        if (keep) begin
          w_q    <= w_q + LenW'(1);
          prev_q <= rdata_q;
        end
        if (op_q == OP_SEARCH && rdata_q == val_q) cnt_q <= cnt_q + LenW'(1);
        if (op_q == OP_INS_SORTED && (val_q < rdata_q)) begin
          idx_q <= i_q;
          i_q   <= len_q;
        end
        if (op_q == OP_READ_ALL) begin
          res_q <= '{STAT_OK, rdata_q, 8'(i_q) + 8'd1, 8'(len_q), last_elem};
        end else begin
          res_q <= '{STAT_OK, val_q, 8'(i_q) + 8'd1, 8'd0, 1'b0};
        end
      end
      S_SHR_WR:  i_q <= i_q - LenW'(1);
      S_DEL_CAP: begin
        vout_q <= rdata_q;
        i_q    <= idx_q;
      end
      S_SHL_WR:  i_q <= i_q + LenW'(1);
      S_REV_RDB: tmp_q <= rdata_q;
      S_REV_WRB: begin
        i_q <= i_q + LenW'(1);
        w_q <= w_q - LenW'(1);
      end
      S_FIN: begin
        res_q <= '{st_q, vout_q, 8'd0,
                   (op_q == OP_SEARCH) ? 8'(cnt_q) : 8'(len_q), 1'b1};
      end
      default: ;
    endcase
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

// ===== sv/pole_checker.sv =====
// Checker: port-level properties of the list engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module pole_checker
  import pole_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire logic busy_o,
  input wire logic res_valid_o,
  input wire res_t res_o
);

  // Every accepted command makes the engine busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("engine not busy after accept");

  // An error status always closes the command.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status != STAT_OK |-> res_o.last)
    else $error("error beat without last");

  // A non-final beat means the command is still running.
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> busy_o) else $error("partial beat while idle");

  // Length or search count reported never exceeds capacity.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_o.count_out <= 8'(Capacity)) else $error("count out of range");

endmodule

bind positional_ordered_list_engine_core pole_checker u_pole_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
  .res_valid_o(res_valid_o), .res_o(res_o)
);
`default_nettype wire
